// ----- hw/rtl/efcb_pkg.sv -----
// ----------------------------------------------------------------------------
// Edge flag coverage blend package
// Shared widths, the stage word passed between the mask and blend stages,
// and the subpixel count helper.
// ----------------------------------------------------------------------------
package efcb_pkg;

    localparam int SUBPIXELS_DEF = 8;
    localparam int SUBPIXELS_MAX = 8;

    localparam int FLAG_W  = 8;
    localparam int PIX_W   = 32;
    localparam int COV_W   = 4;
    localparam int CHAN_W  = 8;
    localparam int NUM_CHAN = PIX_W / CHAN_W;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef logic [FLAG_W-1:0] mask_t;
    typedef logic [PIX_W-1:0]  pixel_t;
    typedef logic [COV_W-1:0]  cov_t;

    typedef struct packed {
        mask_t  mask;
        pixel_t dest;
    } efcb_stage_t;

    function automatic cov_t efcb_popcount(input mask_t v);
        cov_t n;
        n = '0;
        for (int i = 0; i < FLAG_W; i++) begin
            n = n + cov_t'(v[i]);
        end
        return n;
    endfunction

endpackage

// ----- hw/rtl/efcb_mask.sv -----
// ----------------------------------------------------------------------------
// Edge flag coverage blend: mask stage
// Accepts one pixel word, folds its edge flags into the running even-odd
// subpixel mask and registers the new mask with the destination pixel.
// ----------------------------------------------------------------------------
module efcb_mask
    import efcb_pkg::*;
#(
    parameter int SUBPIXELS = SUBPIXELS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  mask_t       flag_word,
    input  pixel_t      dest_pixel,
    input  logic        span_start,
    output logic        out_valid,
    input  logic        out_ready,
    output efcb_stage_t out_stage
);

    localparam mask_t LANE_MASK = mask_t'((1 << SUBPIXELS) - 1);

    logic        valid_reg;
    mask_t       mask_reg;
    mask_t       mask_next;
    efcb_stage_t stage_reg;
    logic        accept;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign mask_next = ((span_start ? '0 : mask_reg) ^ flag_word) & LANE_MASK;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            mask_reg  <= '0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (accept) begin
                mask_reg <= mask_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stage_reg.mask <= mask_next;
            stage_reg.dest <= dest_pixel;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// ----- hw/rtl/efcb_blend.sv -----
// ----------------------------------------------------------------------------
// Edge flag coverage blend: blend stage
// Counts mask bits as coverage alpha, blends the source colour over the
// destination per channel and registers the result word.
// ----------------------------------------------------------------------------
module efcb_blend
    import efcb_pkg::*;
#(
    parameter int SUBPIXELS = SUBPIXELS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  efcb_stage_t in_stage,
    input  pixel_t      source_colour,
    output logic        out_valid,
    input  logic        out_ready,
    output pixel_t      out_pixel,
    output cov_t        coverage
);

    localparam int SUM_W   = CHAN_W + COV_W;
    localparam bit IS_POW2 = (SUBPIXELS & (SUBPIXELS - 1)) == 0;

    logic   valid_reg;
    pixel_t pixel_reg;
    cov_t   cov_reg;
    cov_t   alpha;
    cov_t   inv;
    pixel_t pixel_next;
    logic   accept;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign alpha    = efcb_popcount(in_stage.mask);
    assign inv      = cov_t'(SUBPIXELS) - alpha;

    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
        logic [SUM_W-1:0] sum;
        assign sum = SUM_W'(in_stage.dest[c*CHAN_W +: CHAN_W]) * SUM_W'(inv)
                   + SUM_W'(source_colour[c*CHAN_W +: CHAN_W]) * SUM_W'(alpha);
        if (IS_POW2) begin : g_shift
            localparam int SHIFT = $clog2(SUBPIXELS);
            assign pixel_next[c*CHAN_W +: CHAN_W] = CHAN_W'(sum >> SHIFT);
        end else begin : g_recip
            localparam int RECIP  = (65536 + SUBPIXELS - 1) / SUBPIXELS;
            localparam int PROD_W = SUM_W + 17;
            logic [PROD_W-1:0] prod;
            assign prod = PROD_W'(sum) * PROD_W'(RECIP);
            assign pixel_next[c*CHAN_W +: CHAN_W] = prod[16 +: CHAN_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pixel_reg <= pixel_next;
            cov_reg   <= alpha;
        end
    end

    assign out_valid = valid_reg;
    assign out_pixel = pixel_reg;
    assign coverage  = cov_reg;

endmodule

// ----- hw/rtl/edge_flag_coverage_blend.sv -----
// ----------------------------------------------------------------------------
// Edge flag coverage blend
// Resolves an even-odd edge-flag span: running subpixel mask, coverage
// count and source-over-destination blend, one pixel word per clock while m_tready is high.
//
//   channel   dir  tdata / data (low bit up)           tuser
//   s_        in   flag_word[7:0], dest_pixel[39:8]     span_start
//   m_        out  out_pixel[31:0], coverage[35:32]     -
//   cfg_      in   source_colour[31:0]                  -
//
// From s_ accept to m_ valid a word passes the mask register, then the
// result register after the popcount and per-channel blend.
// One word per clock is sustained; m_tready low holds the result register
// and backs up through the mask stage to s_tready.
// Synchronous active-low reset clears the running mask, source colour and
// valid flags.
// ----------------------------------------------------------------------------
module edge_flag_coverage_blend
    import efcb_pkg::*;
#(
    parameter int SUBPIXELS = SUBPIXELS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // flag_word[7:0], dest_pixel[39:8]
    input  logic                 s_tuser,   // span_start
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // out_pixel[31:0], coverage[35:32]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [PIX_W-1:0]     cfg_data
);

    pixel_t      source_colour_reg;
    logic        stage_valid;
    logic        stage_ready;
    efcb_stage_t stage;
    pixel_t      out_pixel;
    cov_t        coverage;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_colour_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            source_colour_reg <= cfg_data;
        end
    end

    efcb_mask #(
        .SUBPIXELS(SUBPIXELS)
    ) u_mask (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .flag_word (s_tdata[FLAG_W-1:0]),
        .dest_pixel(s_tdata[FLAG_W +: PIX_W]),
        .span_start(s_tuser),
        .out_valid (stage_valid),
        .out_ready (stage_ready),
        .out_stage (stage)
    );

    efcb_blend #(
        .SUBPIXELS(SUBPIXELS)
    ) u_blend (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (stage_valid),
        .in_ready     (stage_ready),
        .in_stage     (stage),
        .source_colour(source_colour_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_pixel    (out_pixel),
        .coverage     (coverage)
    );

    assign m_tdata = {(M_TDATA_W - PIX_W - COV_W)'(0), coverage, out_pixel};

endmodule
